// File: src/cvt_pkg.sv
// Package: shared constants of the colour vote table classifier.
package cvt_pkg;

    localparam int CELLS_Y = 64;
    localparam int CELLS_U = 64;
    localparam int CELLS_V = 64;
    localparam int CLASSES = 10;

    localparam int YW = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
    localparam int UW = (CELLS_U > 1) ? $clog2(CELLS_U) : 1;
    localparam int VW = (CELLS_V > 1) ? $clog2(CELLS_V) : 1;
    localparam int CW = $clog2(CLASSES);
    localparam int N_CELLS = CELLS_Y * CELLS_U * CELLS_V;
    localparam int CELL_AW = $clog2(N_CELLS);
    localparam int N_WEIGHTS = N_CELLS * CLASSES;
    localparam int WEIGHT_AW = $clog2(N_WEIGHTS);
    localparam int CLEAR_W = WEIGHT_AW + 1;

    localparam logic [3:0] NO_WINNER = 4'd15;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_NEIGH = 2'd3;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_UNCLASS = 2'd1;

endpackage

// File: src/colour_vote_table_classifier_core.sv
// Top level of the colour vote table classifier.
// One transaction at a time: after reset a clearing pass over all CELLS_Y*CELLS_U*CELLS_V*CLASSES
// weight addresses (2621440 at default size) writes the weight and label memories, with s_tready low.
// A lookup reads the label memory once, a neighbourhood check once per neighbour; an add
// or subtract updates the single-port weight memory, reads it once per class for the argmax
// and writes the label memory. Every command ends with the result handoff.
// s_tdata: cmd[1:0], cell_y[9:2], cell_u[17:10], cell_v[25:18], class_index[29:26],
// amount[53:30], zero fill to 56 bits. m_tdata: label[3:0], all_match[4], in_range[5].
module colour_vote_table_classifier_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // cmd, cell_y, cell_u, cell_v, class_index, amount
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // label, all_match, in_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] threshold;
    logic [3:0]  unclass_code;
    logic [3:0]  label;
    logic        all_match;
    logic        in_range;

    cvt_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .threshold(threshold), .unclass_code(unclass_code)
    );

    cvt_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(s_tdata[1:0]), .cell_y(s_tdata[9:2]), .cell_u(s_tdata[17:10]),
        .cell_v(s_tdata[25:18]), .class_index(s_tdata[29:26]), .amount(s_tdata[53:30]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .label(label), .all_match(all_match), .in_range(in_range),
        .threshold(threshold), .unclass_code(unclass_code)
    );

    assign m_tdata = {2'b00, in_range, all_match, label};

endmodule

// File: src/cvt_ram.sv
// Generic single-port synchronous RAM with registered read.
module cvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/cvt_regs.sv
// APB configuration registers of the classifier.
module cvt_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] threshold,
    output logic [3:0]  unclass_code
);

    localparam logic REG_SEL_T = cvt_pkg::REG_THRESHOLD[0];

    logic [31:0] threshold_reg;
    logic [3:0]  unclass_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 32'h8000_0000;
            unclass_reg   <= 4'd15;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_SEL_T:
                begin
                    threshold_reg <= pwdata;
                end
                default:
                begin
                    unclass_reg <= pwdata[3:0];
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_SEL_T:
                begin
                    prdata = threshold_reg;
                end
                default:
                begin
                    prdata = {28'd0, unclass_reg};
                end
            endcase
        end
    end

    assign threshold    = threshold_reg;
    assign unclass_code = unclass_reg;

endmodule

// File: src/cvt_engine.sv
// Command sequencer: clear pass, read-modify-write of weights, argmax, label reads.
module cvt_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  cell_y,
    input  logic [7:0]  cell_u,
    input  logic [7:0]  cell_v,
    input  logic [3:0]  class_index,
    input  logic [23:0] amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  label,
    output logic        all_match,
    output logic        in_range,
    input  logic [31:0] threshold,
    input  logic [3:0]  unclass_code
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRD, S_WMOD, S_ARG, S_LWR,
        S_LRD, S_LCHK, S_OUT
    } state_t;

    state_t                       state_reg;
    logic [cvt_pkg::CLEAR_W-1:0]  clr_reg;
    logic [1:0]                   cmd_reg;
    logic [7:0]                   y_reg, u_reg, v_reg;
    logic [3:0]                   cls_reg;
    logic signed [23:0]           amt_reg;
    logic                         ok_reg;
    logic [3:0]                   idx_reg;
    logic [3:0]                   step_reg;
    logic signed [31:0]           best_reg;
    logic [3:0]                   win_reg;
    logic                         match_reg;
    logic [3:0]                   label_reg;
    logic                         nb_in_reg;

    logic                           w_we;
    logic [cvt_pkg::WEIGHT_AW-1:0]  w_addr;
    logic [31:0]                    w_wdata, w_rdata;
    logic                           l_we;
    logic [cvt_pkg::CELL_AW-1:0]    l_addr;
    logic [3:0]                     l_wdata, l_rdata;

    cvt_ram #(.WIDTH(32), .DEPTH(cvt_pkg::N_WEIGHTS)) u_weight (
        .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata)
    );

    cvt_ram #(.WIDTH(4), .DEPTH(cvt_pkg::N_CELLS)) u_label (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
    );

    // neighbour coordinates for step 0..6 (center first)
    logic signed [9:0] ny, nu, nv;
    logic              n_in;
    logic [cvt_pkg::CELL_AW-1:0] n_addr, c_addr;
    logic [cvt_pkg::WEIGHT_AW-1:0] c_base;

    always_comb
    begin
        ny = {2'b00, y_reg};
        nu = {2'b00, u_reg};
        nv = {2'b00, v_reg};
        case (step_reg)
            4'd1: ny = ny - 10'sd1;
            4'd2: ny = ny + 10'sd1;
            4'd3: nu = nu - 10'sd1;
            4'd4: nu = nu + 10'sd1;
            4'd5: nv = nv - 10'sd1;
            4'd6: nv = nv + 10'sd1;
            default: ;
        endcase
        n_in = (ny >= 0) && (ny < 10'(cvt_pkg::CELLS_Y)) && (nu >= 0)
            && (nu < 10'(cvt_pkg::CELLS_U)) && (nv >= 0)
            && (nv < 10'(cvt_pkg::CELLS_V));
        n_addr = cvt_pkg::CELL_AW'((32'(ny[7:0]) * cvt_pkg::CELLS_U + 32'(nu[7:0]))
            * cvt_pkg::CELLS_V + 32'(nv[7:0]));
        c_addr = cvt_pkg::CELL_AW'((32'(y_reg) * cvt_pkg::CELLS_U + 32'(u_reg))
            * cvt_pkg::CELLS_V + 32'(v_reg));
        c_base = cvt_pkg::WEIGHT_AW'(32'(c_addr) * cvt_pkg::CLASSES);
    end

    logic signed [32:0] sum;
    logic signed [31:0] sat;
    logic [3:0]         lmap;

    always_comb
    begin
        if (cmd_reg == cvt_pkg::CMD_ADD)
        begin
            sum = 33'(signed'(w_rdata)) + 33'(amt_reg);
        end
        else
        begin
            sum = 33'(signed'(w_rdata)) - 33'(amt_reg);
        end
        if (sum[32] != sum[31])
        begin
            sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            sat = sum[31:0];
        end
        lmap = (l_rdata == cvt_pkg::NO_WINNER) ? unclass_code : l_rdata;
    end

    always_comb
    begin
        w_we    = 1'b0;
        w_wdata = sat;
        w_addr  = c_base + cvt_pkg::WEIGHT_AW'(cls_reg);
        l_we    = 1'b0;
        l_wdata = win_reg;
        l_addr  = c_addr;
        unique case (state_reg)
            S_CLEAR:
            begin
                w_we    = 1'b1;
                w_wdata = 32'd0;
                w_addr  = clr_reg[cvt_pkg::WEIGHT_AW-1:0];
                l_we    = (clr_reg < cvt_pkg::CLEAR_W'(cvt_pkg::N_CELLS));
                l_wdata = cvt_pkg::NO_WINNER;
                l_addr  = clr_reg[cvt_pkg::CELL_AW-1:0];
            end
            S_WMOD:
            begin
                w_we = 1'b1;
            end
            S_ARG:
            begin
                w_addr = c_base + cvt_pkg::WEIGHT_AW'(idx_reg);
            end
            S_LWR:
            begin
                l_we = 1'b1;
            end
            S_LRD, S_LCHK:
            begin
                l_addr = n_addr;
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign label     = label_reg;
    assign all_match = match_reg;
    assign in_range  = ok_reg;

    logic ok_in;
    assign ok_in = ({1'b0, cell_y} < 9'(cvt_pkg::CELLS_Y))
        && ({1'b0, cell_u} < 9'(cvt_pkg::CELLS_U))
        && ({1'b0, cell_v} < 9'(cvt_pkg::CELLS_V));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == cvt_pkg::CLEAR_W'(cvt_pkg::N_WEIGHTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd;
                        y_reg     <= cell_y;
                        u_reg     <= cell_u;
                        v_reg     <= cell_v;
                        cls_reg   <= class_index;
                        amt_reg   <= amount;
                        ok_reg    <= ok_in;
                        match_reg <= 1'b1;
                        step_reg  <= '0;
                        if ((cmd == cvt_pkg::CMD_ADD || cmd == cvt_pkg::CMD_SUB) && ok_in
                            && class_index < 4'(cvt_pkg::CLASSES))
                        begin
                            state_reg <= S_WRD;
                        end
                        else
                        begin
                            state_reg <= S_LRD;
                        end
                    end
                end
                S_WRD:
                begin
                    state_reg <= S_WMOD;
                end
                S_WMOD:
                begin
                    idx_reg   <= '0;
                    step_reg  <= '0;
                    best_reg  <= threshold;
                    win_reg   <= cvt_pkg::NO_WINNER;
                    state_reg <= S_ARG;
                end
                S_ARG:
                begin
                    // data of class step_reg-1 arrives while class idx_reg is addressed
                    if (step_reg != 4'd0)
                    begin
                        if (signed'(w_rdata) > best_reg)
                        begin
                            best_reg <= w_rdata;
                            win_reg  <= step_reg - 4'd1;
                        end
                    end
                    step_reg <= step_reg + 4'd1;
                    if (idx_reg != 4'(cvt_pkg::CLASSES - 1))
                    begin
                        idx_reg <= idx_reg + 4'd1;
                    end
                    if (step_reg == 4'(cvt_pkg::CLASSES))
                    begin
                        state_reg <= S_LWR;
                    end
                end
                S_LWR:
                begin
                    step_reg  <= '0;
                    state_reg <= S_LRD;
                end
                S_LRD:
                begin
                    nb_in_reg <= n_in;
                    state_reg <= S_LCHK;
                end
                S_LCHK:
                begin
                    if (step_reg == 4'd0)
                    begin
                        label_reg <= ok_reg ? lmap : unclass_code;
                    end
                    if (cmd_reg != cvt_pkg::CMD_NEIGH)
                    begin
                        match_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if ((nb_in_reg ? lmap : unclass_code) != cls_reg)
                        begin
                            match_reg <= 1'b0;
                        end
                        if (step_reg == 4'd6)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= S_LRD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/tb_colour_vote_table_classifier_core.sv
// Testbench for the colour vote table classifier core: randomized commands checked against a table model.
`timescale 1ns / 100ps

module tb_colour_vote_table_classifier_core;

    typedef struct packed {
        logic [23:0] amount;
        logic [3:0]  class_index;
        logic [7:0]  cell_v;
        logic [7:0]  cell_u;
        logic [7:0]  cell_y;
        logic [1:0]  cmd;
    } cmd_t;

    typedef struct packed {
        logic       in_range;
        logic       all_match;
        logic [3:0] label;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    colour_vote_table_classifier_core uut (.*);

    always #1 clk = ~clk;

    // sparse model of the table; untouched cells hold zero weights and no winner
    logic signed [31:0] vote_weight [int];
    logic [3:0]         cached_label [int];
    logic signed [31:0] thr = 32'sh80000000;
    logic [3:0]         unclass = 4'd15;

    cmd_t     pending_cmds [$];
    verdict_t expected_verdicts [$];
    int       errors = 0;
    int       results_seen = 0;
    int       cmds_sent = 0;
    bit       hold_sender = 1'b0;

    function automatic int cell_key(int y, int u, int v);
        return (y * cvt_pkg::CELLS_U + u) * cvt_pkg::CELLS_V + v;
    endfunction

    function automatic bit within_table(int y, int u, int v);
        return y >= 0 && y < cvt_pkg::CELLS_Y && u >= 0 && u < cvt_pkg::CELLS_U
            && v >= 0 && v < cvt_pkg::CELLS_V;
    endfunction

    function automatic logic [3:0] label_at(int y, int u, int v);
        logic [3:0] l;
        if (!within_table(y, u, v))
            return unclass;
        l = cached_label.exists(cell_key(y, u, v)) ? cached_label[cell_key(y, u, v)]
            : cvt_pkg::NO_WINNER;
        return (l == cvt_pkg::NO_WINNER) ? unclass : l;
    endfunction

    function automatic verdict_t classify(cmd_t c);
        verdict_t r;
        int y, u, v, key, wk;
        logic signed [33:0] w;
        logic signed [31:0] best;
        logic [3:0] idx;
        y = int'(c.cell_y);
        u = int'(c.cell_u);
        v = int'(c.cell_v);
        r = '0;
        r.in_range = within_table(y, u, v);
        if ((c.cmd == cvt_pkg::CMD_ADD || c.cmd == cvt_pkg::CMD_SUB) && r.in_range
            && c.class_index < cvt_pkg::CLASSES)
        begin
            key = cell_key(y, u, v);
            wk = key * cvt_pkg::CLASSES + int'(c.class_index);
            w = vote_weight.exists(wk) ? 34'(vote_weight[wk]) : 34'sd0;
            if (c.cmd == cvt_pkg::CMD_ADD)
                w = w + 34'($signed(c.amount));
            else
                w = w - 34'($signed(c.amount));
            if (w > 34'sd2147483647)
                w = 34'sd2147483647;
            if (w < -34'sd2147483648)
                w = -34'sd2147483648;
            vote_weight[wk] = w[31:0];
            best = thr;
            idx = cvt_pkg::NO_WINNER;
            for (int i = 0; i < cvt_pkg::CLASSES; i++)
            begin
                w = vote_weight.exists(key * cvt_pkg::CLASSES + i)
                    ? 34'(vote_weight[key * cvt_pkg::CLASSES + i]) : 34'sd0;
                if (w > 34'(best))
                begin
                    best = w[31:0];
                    idx = 4'(i);
                end
            end
            cached_label[key] = idx;
        end
        if (c.cmd == cvt_pkg::CMD_NEIGH)
            r.all_match = label_at(y, u, v) == c.class_index &&
                label_at(y - 1, u, v) == c.class_index && label_at(y + 1, u, v) == c.class_index &&
                label_at(y, u - 1, v) == c.class_index && label_at(y, u + 1, v) == c.class_index &&
                label_at(y, u, v - 1) == c.class_index && label_at(y, u, v + 1) == c.class_index;
        r.label = label_at(y, u, v);
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] op, int y, int u, int v, int cls, int amt);
        cmd_t c;
        c.cmd = op;
        c.cell_y = 8'(y);
        c.cell_u = 8'(u);
        c.cell_v = 8'(v);
        c.class_index = 4'(cls);
        c.amount = 24'(amt);
        return c;
    endfunction

    task automatic queue_cmd(cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic queue_verdict(verdict_t r);
        expected_verdicts = {expected_verdicts, r};
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 40))
            : int'($urandom_range(0, 3));
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                queue_verdict(classify(cmd_t'(s_tdata[53:0])));
                cmds_sent <= cmds_sent + 1;
                send_gap = rand_gap();
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !hold_sender)
                begin
                    s_tdata <= {2'b0, pending_cmds.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk)
    begin
        verdict_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[5:0];
                results_seen <= results_seen + 1;
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.label !== want.label)
                    begin
                        $error("label expected %0d actual %0d", want.label, got.label);
                        errors++;
                    end
                    if (got.all_match !== want.all_match)
                    begin
                        $error("all_match expected %0d actual %0d", want.all_match, got.all_match);
                        errors++;
                    end
                    if (got.in_range !== want.in_range)
                    begin
                        $error("in_range expected %0d actual %0d", want.in_range, got.in_range);
                        errors++;
                    end
                end
                recv_gap = rand_gap();
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == cvt_pkg::REG_THRESHOLD)
            thr = value;
        else
            unclass = value[3:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // nine in ten commands stay near four table corners so cells get repeated votes
    function automatic cmd_t rand_cmd();
        int y, u, v, amt;
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
        begin
            y = int'($urandom_range(0, 255));
            u = int'($urandom_range(0, 255));
            v = int'($urandom_range(0, 255));
        end
        else
        begin
            y = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 3))
                : int'($urandom_range(60, 64));
            u = int'($urandom_range(0, 3));
            v = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 3))
                : int'($urandom_range(60, 63));
        end
        case ($urandom_range(0, 5))
            0: amt = 24'h7FFFFF;
            1: amt = 24'h800000;
            2: amt = int'($urandom);
            default: amt = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return make_cmd(op, y, u, v, int'($urandom_range(0, 15)), amt);
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(cvt_pkg::REG_THRESHOLD, 32'sd0);
        write_reg(cvt_pkg::REG_UNCLASS, 32'd12);
        // directed: field extremes, each command, out of range, bad class, table edges, ties
        queue_cmd(make_cmd(cvt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 0, 0, 0, 3, 24'h7FFFFF));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 0, 0, 0, 3, 24'h7FFFFF));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 0, 0, 0, 1, 24'h800000));
        queue_cmd(make_cmd(cvt_pkg::CMD_SUB, 0, 0, 0, 1, 24'h800000));
        queue_cmd(make_cmd(cvt_pkg::CMD_SUB, 0, 0, 0, 1, 24'h7FFFFF));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 0, 0, 0, 15, 100));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 0, 0, 0, 9, 24'hFFFFFF));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 1, 1, 1, 2, 50));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 1, 1, 1, 4, 50));
        queue_cmd(make_cmd(cvt_pkg::CMD_ADD, 255, 255, 255, 2, 50));
        queue_cmd(make_cmd(cvt_pkg::CMD_LOOKUP, 64, 0, 0, 0, 0));
        queue_cmd(make_cmd(cvt_pkg::CMD_LOOKUP, 63, 63, 63, 0, 0));
        queue_cmd(make_cmd(cvt_pkg::CMD_NEIGH, 0, 0, 0, 12, 0));
        queue_cmd(make_cmd(cvt_pkg::CMD_NEIGH, 200, 0, 0, 12, 0));
        queue_cmd(make_cmd(cvt_pkg::CMD_NEIGH, 63, 63, 63, 12, 0));
        queue_cmd(make_cmd(cvt_pkg::CMD_NEIGH, 1, 1, 1, 2, 0));
        drain();
        hold_sender = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < 100; i++)
                queue_cmd(rand_cmd());
            drain();
            case (p)
                0:
                begin
                    write_reg(cvt_pkg::REG_THRESHOLD, 32'h7FFFFFFF);
                    write_reg(cvt_pkg::REG_UNCLASS, 32'd0);
                end
                1:
                begin
                    write_reg(cvt_pkg::REG_THRESHOLD, 32'h80000000);
                    write_reg(cvt_pkg::REG_UNCLASS, 32'd15);
                end
                default:
                begin
                    write_reg(cvt_pkg::REG_THRESHOLD, $urandom_range(0, 4000) - 32'd2000);
                    write_reg(cvt_pkg::REG_UNCLASS, $urandom_range(0, 15));
                end
            endcase
        end
        $display("Sent %0d commands, checked %0d results across threshold/code settings,",
                 cmds_sent, results_seen);
        $display("with saturation, out-of-range cells, table edges and neighbourhood checks.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
